// File: rtl/tns_pkg.sv
`default_nettype none
package tns_pkg;

    // lattice geometry
    localparam int MAX_SIDE = 64;
    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int SIDE_W   = 7;

    // value widths
    localparam int VAL_W    = 24;
    localparam int SUM_W    = 26;
    localparam int CELL_W   = 2 * VAL_W;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_OOB = 1'b1;

    // bounds result and neighbor addresses of one item
    typedef struct packed {
        logic              oob;
        logic [ADDR_W-1:0] a_self;
        logic [ADDR_W-1:0] a_left;
        logic [ADDR_W-1:0] a_right;
        logic [ADDR_W-1:0] a_up;
        logic [ADDR_W-1:0] a_down;
    } tns_nbr_t;

endpackage
`default_nettype wire

// File: rtl/tns_ram.sv
`default_nettype none
module tns_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

// File: rtl/tns_neigh.sv
`default_nettype none
module tns_neigh
    import tns_pkg::*;
(
    input  wire logic [SIDE_W-1:0] lattice_side,
    input  wire logic [IDX_W-1:0]  cell_row,
    input  wire logic [IDX_W-1:0]  cell_col,
    output tns_nbr_t               nbr
);

    logic [SIDE_W-1:0] side;
    logic [SIDE_W-1:0] side_m1;
    logic [IDX_W-1:0]  last;
    logic [IDX_W-1:0]  up;
    logic [IDX_W-1:0]  down;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;

    // saturate the side, side of zero flags everything
    always_comb
    begin
        side    = (lattice_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : lattice_side;
        side_m1 = side - SIDE_W'(1);
        last    = side_m1[IDX_W-1:0];
    end

    // periodic neighbor indexes
    always_comb
    begin
        up    = (cell_row != '0) ? cell_row - IDX_W'(1) : last;
        down  = ({1'b0, cell_row} < side_m1) ? cell_row + IDX_W'(1) : '0;
        left  = (cell_col != '0) ? cell_col - IDX_W'(1) : last;
        right = ({1'b0, cell_col} < side_m1) ? cell_col + IDX_W'(1) : '0;
    end

    // bounds check and row-major addresses
    always_comb
    begin
        nbr.oob     = ({1'b0, cell_row} >= side) || ({1'b0, cell_col} >= side);
        nbr.a_self  = {cell_row, cell_col};
        nbr.a_left  = {cell_row, left};
        nbr.a_right = {cell_row, right};
        nbr.a_up    = {up, cell_col};
        nbr.a_down  = {down, cell_col};
    end

endmodule
`default_nettype wire

// File: rtl/torus_neighbour_sum.sv
// pipeline: input register, registered store reads with the read stage, then result register
// throughput: one item per cycle when not stalled or clearing, set by dual-read store copies
// reset: rst_n is asynchronous, active low; lattice_side resets to 64
// after reset a clearing pass zeroes all 4096 cells, one per cycle, during
// which s_tready stays low; configuration writes are taken throughout
`default_nettype none
module torus_neighbour_sum
    import tns_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SIDE_W-1:0] cfg_data,    // lattice_side
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [63:0]       s_tdata,     // cell_row, cell_col, value_re, value_im, pad
    input  wire logic [0:0]        s_tuser,     // req_type
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [55:0]       m_tdata,     // corona_re, corona_im, pad
    output logic      [0:0]        m_tuser      // status
);

    logic [SIDE_W-1:0] side_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              s0_valid_reg;
    logic              s0_query_reg;
    logic [IDX_W-1:0]  s0_row_reg;
    logic [IDX_W-1:0]  s0_col_reg;
    logic [VAL_W-1:0]  s0_re_reg;
    logic [VAL_W-1:0]  s0_im_reg;

    logic              s1_valid_reg;
    logic              s1_query_reg;
    logic              s1_oob_reg;

    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_re_reg;
    logic [SUM_W-1:0]  out_im_reg;
    logic              out_status_reg;

    logic              adv1;
    logic              adv2;
    logic              in_xfer;
    tns_nbr_t          nbr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] rd_left;
    logic [CELL_W-1:0] rd_right;
    logic [CELL_W-1:0] rd_up;
    logic [CELL_W-1:0] rd_down;

    logic [SUM_W-1:0]  sum_re_next;
    logic [SUM_W-1:0]  sum_im_next;

    // pipeline advance
    assign adv2      = !out_valid_reg || m_tready;
    assign adv1      = !s1_valid_reg || adv2;
    assign s_tready  = adv1 && !clr_busy_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_W'(MAX_SIDE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            side_reg <= cfg_data;
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s0_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s0_query_reg <= s_tuser[0];
            s0_row_reg   <= s_tdata[5:0];
            s0_col_reg   <= s_tdata[11:6];
            s0_re_reg    <= s_tdata[35:12];
            s0_im_reg    <= s_tdata[59:36];
        end
    end

    // bounds and neighbor addresses
    tns_neigh u_neigh (
        .lattice_side (side_reg),
        .cell_row     (s0_row_reg),
        .cell_col     (s0_col_reg),
        .nbr          (nbr)
    );

    // store write: clearing pass or an accepted in-range write
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = adv1 && s0_valid_reg && (s0_query_reg == REQ_WRITE) && !nbr.oob;
            ram_waddr = nbr.a_self;
            ram_wdata = {s0_im_reg, s0_re_reg};
        end
    end

    // horizontal neighbors copy
    tns_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram_h (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (adv1),
        .raddr_a (nbr.a_left),
        .raddr_b (nbr.a_right),
        .rdata_a (rd_left),
        .rdata_b (rd_right)
    );

    // vertical neighbors copy
    tns_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_ram_v (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (adv1),
        .raddr_a (nbr.a_up),
        .raddr_b (nbr.a_down),
        .rdata_a (rd_up),
        .rdata_b (rd_down)
    );

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_query_reg <= s0_query_reg;
            s1_oob_reg   <= nbr.oob;
        end
    end

    // four-neighbor sums, sign extended
    always_comb
    begin
        sum_re_next =
            {{(SUM_W-VAL_W){rd_left[VAL_W-1]}},   rd_left[VAL_W-1:0]}
          + {{(SUM_W-VAL_W){rd_right[VAL_W-1]}},  rd_right[VAL_W-1:0]}
          + {{(SUM_W-VAL_W){rd_up[VAL_W-1]}},     rd_up[VAL_W-1:0]}
          + {{(SUM_W-VAL_W){rd_down[VAL_W-1]}},   rd_down[VAL_W-1:0]};
        sum_im_next =
            {{(SUM_W-VAL_W){rd_left[CELL_W-1]}},  rd_left[CELL_W-1:VAL_W]}
          + {{(SUM_W-VAL_W){rd_right[CELL_W-1]}}, rd_right[CELL_W-1:VAL_W]}
          + {{(SUM_W-VAL_W){rd_up[CELL_W-1]}},    rd_up[CELL_W-1:VAL_W]}
          + {{(SUM_W-VAL_W){rd_down[CELL_W-1]}},  rd_down[CELL_W-1:VAL_W]};
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            out_status_reg <= s1_oob_reg ? ST_OOB : ST_OK;
            if ((s1_query_reg == REQ_QUERY) && !s1_oob_reg)
            begin
                out_re_reg <= sum_re_next;
                out_im_reg <= sum_im_next;
            end
            else
            begin
                out_re_reg <= '0;
                out_im_reg <= '0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0, out_im_reg, out_re_reg};
    assign m_tuser[0] = out_status_reg;

    // no item is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_tready && !s0_valid_reg && !s1_valid_reg)
        else $error("item in flight during clearing pass");

    // a flagged result carries zero sums
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == ST_OOB) |-> m_tdata == '0)
        else $error("flagged result with nonzero sum");

    // a stalled read stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv2 |=> s1_valid_reg && $stable(s1_query_reg) && $stable(s1_oob_reg))
        else $error("read stage lost its item under stall");

    // store writes only come from a transfer leaving the input register
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && !clr_busy_reg |-> s0_valid_reg && adv1)
        else $error("store write without an advancing item");

endmodule
`default_nettype wire
